// File: design/irafmt_pkg.sv
// Shared types, constants and helpers of the integer radix ASCII formatter.
package irafmt_pkg;

   localparam int VALUE_W = 32;
   localparam int WIDTH_W = 6;
   localparam int DIG_W = 4;
   localparam int MAX_POS = 11;
   localparam int POS_W = 4;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W = BCD_DIGITS * DIG_W;
   localparam int DD_STAGES = 4;
   localparam int DD_STEPS = VALUE_W / DD_STAGES;

   localparam logic [2:0] ACT_SDEC = 3'd0;
   localparam logic [2:0] ACT_UDEC = 3'd1;
   localparam logic [2:0] ACT_HEXL = 3'd2;
   localparam logic [2:0] ACT_HEXU = 3'd3;
   localparam logic [2:0] ACT_OCT = 3'd4;

   localparam logic [POS_W-1:0] POS_DEC = 4'd10;
   localparam logic [POS_W-1:0] POS_HEX = 4'd8;
   localparam logic [POS_W-1:0] POS_OCT = 4'd11;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   typedef enum logic [1:0] {
      RAD_DEC,
      RAD_HEX,
      RAD_OCT
   } radix_type;

   // Decoded request as it travels down the pipeline.
   typedef struct packed {
      radix_type             radix;
      logic                  upper;
      logic                  neg;
      logic                  zero_fill;
      logic [WIDTH_W-1:0]    width;
      logic [VALUE_W-1:0]    mag;
   } item_type;

   function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (d <= 4'd9) begin
         return CHAR_ZERO + {4'd0, d};
      end
      return base + {4'd0, d} - 8'd10;
   endfunction

endpackage

// File: design/irafmt_if.sv
// Request and response channel interfaces of the radix formatter.
interface irafmt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] value;
   logic [5:0]  pad_width;
   logic        zero_fill;

   modport source (output valid, output action, output value, output pad_width,
                   output zero_fill, input ready);
   modport sink (input valid, input action, input value, input pad_width,
                 input zero_fill, output ready);
endinterface

interface irafmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink (input valid, input char_out, input last, output ready);
endinterface

// File: design/integer_radix_ascii_formatter_core.sv
// Top level of the integer radix ASCII formatter: decode, BCD pipeline, digit pack, serializer.
// An accepted request passes the decode stage, four double-dabble stages, digit pack, serializer
// and response register before its first character reaches the response channel.
// Throughput: one character per cycle while the response channel is ready; a request sends
// one to eleven characters, set by the single-character serializer at the end of the pipeline.
// Reset is synchronous and active high; it clears every valid bit and the serializer.
module integer_radix_ascii_formatter_core (
   input  logic         clock,
   input  logic         reset,
   irafmt_req_if.sink   req_chan,
   irafmt_rsp_if.source rsp_chan
);
   import irafmt_pkg::*;

   // ---------------------------------------------------------------------------------------
   // Stage 1: decode the action, negate negative signed values and trim the field width.
   // ---------------------------------------------------------------------------------------
   logic      s1_valid_ff;
   item_type  s1_item_ff, s1_item_in;
   logic      s1_load;

   always_comb begin
      s1_item_in.upper = 1'b0;
      s1_item_in.neg = 1'b0;
      s1_item_in.zero_fill = req_chan.zero_fill;
      s1_item_in.width = req_chan.pad_width;
      s1_item_in.mag = req_chan.value;
      case (req_chan.action)
         ACT_HEXL: s1_item_in.radix = RAD_HEX;
         ACT_HEXU: begin
            s1_item_in.radix = RAD_HEX;
            s1_item_in.upper = 1'b1;
         end
         ACT_OCT: s1_item_in.radix = RAD_OCT;
         default: s1_item_in.radix = RAD_DEC;
      endcase
      if (req_chan.action == ACT_SDEC && req_chan.value[VALUE_W-1]) begin
         // The sign takes one column of the field; the width never wraps below zero.
         s1_item_in.neg = 1'b1;
         s1_item_in.mag = ~req_chan.value + 32'd1;
         s1_item_in.width = (req_chan.pad_width != '0) ? req_chan.pad_width - 6'd1 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_item_ff <= s1_item_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stages 2 to 5: double dabble, eight bits of the magnitude per stage. Hex and octal
   // requests ride along; their digits come straight from the magnitude later on.
   // ---------------------------------------------------------------------------------------
   logic              dd_valid [DD_STAGES+1];
   item_type          dd_item  [DD_STAGES+1];
   logic [BCD_W-1:0]  dd_bcd   [DD_STAGES+1];
   logic [VALUE_W-1:0] dd_bin  [DD_STAGES+1];
   logic              dd_load  [DD_STAGES];
   logic              s6_load;

   assign dd_valid[0] = s1_valid_ff;
   assign dd_item[0] = s1_item_ff;
   assign dd_bcd[0] = '0;
   assign dd_bin[0] = s1_item_ff.mag;

   for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
      irafmt_dd_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .load      (dd_load[g]),
         .in_valid  (dd_valid[g]),
         .in_item   (dd_item[g]),
         .in_bcd    (dd_bcd[g]),
         .in_bin    (dd_bin[g]),
         .out_valid (dd_valid[g+1]),
         .out_item  (dd_item[g+1]),
         .out_bcd   (dd_bcd[g+1]),
         .out_bin   (dd_bin[g+1])
      );
   end

   // A stage takes new data when it is empty or when the stage after it moves on.
   always_comb begin
      logic nxt;
      nxt = s6_load;
      for (int k = DD_STAGES - 1; k >= 0; k--) begin
         dd_load[k] = !dd_valid[k+1] || nxt;
         nxt = dd_load[k];
      end
   end

   assign s1_load = !s1_valid_ff || dd_load[0];
   assign req_chan.ready = s1_load;

   // ---------------------------------------------------------------------------------------
   // Stage 6: gather the digit positions, find the significant digit count and the number
   // of positions to send (the larger of the digit count and the clamped field width).
   // ---------------------------------------------------------------------------------------
   logic                  s6_valid_ff;
   logic [DIG_W-1:0]      s6_dig_ff [MAX_POS];
   logic [DIG_W-1:0]      s6_dig_in [MAX_POS];
   logic [POS_W-1:0]      s6_ndig_ff, s6_ndig_in;
   logic [POS_W-1:0]      s6_len_ff, s6_len_in;
   logic                  s6_neg_ff, s6_upper_ff, s6_zero_fill_ff;

   always_comb begin
      item_type          it;
      logic [POS_W-1:0]  npos;
      logic [POS_W-1:0]  wclamp;
      it = dd_item[DD_STAGES];
      for (int p = 0; p < MAX_POS; p++) begin
         s6_dig_in[p] = '0;
      end
      case (it.radix)
         RAD_HEX: begin
            npos = POS_HEX;
            for (int p = 0; p < 8; p++) begin
               s6_dig_in[p] = it.mag[p*4 +: 4];
            end
         end
         RAD_OCT: begin
            npos = POS_OCT;
            for (int p = 0; p < 10; p++) begin
               s6_dig_in[p] = {1'b0, it.mag[p*3 +: 3]};
            end
            s6_dig_in[10] = {2'b00, it.mag[31:30]};
         end
         default: begin
            npos = POS_DEC;
            for (int p = 0; p < BCD_DIGITS; p++) begin
               s6_dig_in[p] = dd_bcd[DD_STAGES][p*DIG_W +: DIG_W];
            end
         end
      endcase
      // A zero value still sends its least significant digit.
      s6_ndig_in = 4'd1;
      for (int p = 1; p < MAX_POS; p++) begin
         if (s6_dig_in[p] != '0) begin
            s6_ndig_in = POS_W'(p + 1);
         end
      end
      wclamp = (it.width < {2'b00, npos}) ? it.width[POS_W-1:0] : npos;
      s6_len_in = (wclamp > s6_ndig_in) ? wclamp : s6_ndig_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (s6_load) begin
         s6_valid_ff <= dd_valid[DD_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (s6_load) begin
         s6_dig_ff <= s6_dig_in;
         s6_ndig_ff <= s6_ndig_in;
         s6_len_ff <= s6_len_in;
         s6_neg_ff <= dd_item[DD_STAGES].neg;
         s6_upper_ff <= dd_item[DD_STAGES].upper;
         s6_zero_fill_ff <= dd_item[DD_STAGES].zero_fill;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Serializer: sends the sign, then positions from the highest down to one. Positions
   // above the digit count are fill characters. The response register sits behind it, so
   // a waiting character never blocks the pipeline from filling up behind it.
   // ---------------------------------------------------------------------------------------
   logic              ser_valid_ff, ser_valid_in;
   logic              ser_sign_ff, ser_sign_in;
   logic [POS_W-1:0]  ser_pos_ff, ser_pos_in;
   logic [POS_W-1:0]  ser_ndig_ff;
   logic [DIG_W-1:0]  ser_dig_ff [MAX_POS];
   logic              ser_upper_ff, ser_zero_fill_ff;
   logic              ser_load;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              emit;
   logic              emit_last;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit = ser_valid_ff && out_free;
   assign emit_last = !ser_sign_ff && ser_pos_ff == 4'd1;
   assign ser_load = !ser_valid_ff || (emit && emit_last);
   assign s6_load = !s6_valid_ff || ser_load;

   always_comb begin
      logic [POS_W-1:0] idx;
      idx = ser_pos_ff - 4'd1;
      if (ser_sign_ff) begin
         rsp_char_in = CHAR_MINUS;
      end else if (ser_pos_ff > ser_ndig_ff) begin
         rsp_char_in = ser_zero_fill_ff ? CHAR_ZERO : CHAR_SPACE;
      end else begin
         rsp_char_in = digit_char(ser_dig_ff[idx], ser_upper_ff);
      end
      rsp_last_in = emit_last;
   end

   always_comb begin
      ser_valid_in = ser_valid_ff;
      ser_sign_in = ser_sign_ff;
      ser_pos_in = ser_pos_ff;
      if (ser_load) begin
         ser_valid_in = s6_valid_ff;
         ser_sign_in = s6_neg_ff;
         ser_pos_in = s6_len_ff;
      end else if (emit) begin
         if (ser_sign_ff) begin
            ser_sign_in = 1'b0;
         end else begin
            ser_pos_in = ser_pos_ff - 4'd1;
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_sign_ff <= 1'b0;
         ser_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ser_valid_ff <= ser_valid_in;
         ser_sign_ff <= ser_sign_in;
         ser_pos_ff <= ser_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_ndig_ff <= s6_ndig_ff;
         ser_dig_ff <= s6_dig_ff;
         ser_upper_ff <= s6_upper_ff;
         ser_zero_fill_ff <= s6_zero_fill_ff;
      end
      if (emit) begin
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.char_out = rsp_char_ff;
   assign rsp_chan.last = rsp_last_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------------

   // A busy serializer always has a position left between one and eleven.
   a_ser_pos_range: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> (ser_pos_ff >= 4'd1 && ser_pos_ff <= 4'd11))
      else $error("serializer position out of range");

   // A packed request that the serializer cannot take stays put.
   a_s6_hold: assert property (@(posedge clock) disable iff (reset)
      (s6_valid_ff && !ser_load) |=> (s6_valid_ff && $stable(s6_len_ff)))
      else $error("stage six lost a request while stalled");

   // Each rise of the response valid comes from a character of a busy serializer.
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> $past(ser_valid_ff))
      else $error("response valid without a serializer request");

   // Once the last character is sent and no packed request waits, the serializer goes idle.
   a_last_reload: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last && !s6_valid_ff) |=> !ser_valid_ff)
      else $error("serializer kept running after the last character");

endmodule

// File: design/irafmt_dd_stage.sv
// One registered stage of the pipelined binary to BCD double-dabble converter.
module irafmt_dd_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         in_valid,
   input  irafmt_pkg::item_type         in_item,
   input  logic [irafmt_pkg::BCD_W-1:0] in_bcd,
   input  logic [irafmt_pkg::VALUE_W-1:0] in_bin,
   output logic                         out_valid,
   output irafmt_pkg::item_type         out_item,
   output logic [irafmt_pkg::BCD_W-1:0] out_bcd,
   output logic [irafmt_pkg::VALUE_W-1:0] out_bin
);
   import irafmt_pkg::*;

   logic                 valid_ff;
   item_type             item_ff;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [VALUE_W-1:0]   bin_ff, bin_in;

   // Each step adds three to any digit of five or more, then shifts one bit in.
   always_comb begin
      logic [BCD_W-1:0]   b;
      logic [VALUE_W-1:0] s;
      b = in_bcd;
      s = in_bin;
      for (int st = 0; st < DD_STEPS; st++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (b[d*DIG_W +: DIG_W] >= 4'd5) begin
               b[d*DIG_W +: DIG_W] = b[d*DIG_W +: DIG_W] + 4'd3;
            end
         end
         b = {b[BCD_W-2:0], s[VALUE_W-1]};
         s = {s[VALUE_W-2:0], 1'b0};
      end
      bcd_in = b;
      bin_in = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
         bcd_ff <= bcd_in;
         bin_ff <= bin_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;
   assign out_bcd = bcd_ff;
   assign out_bin = bin_ff;

endmodule
